### hw/rtl/msrs_pkg.sv
// Shared types, codes and constants of the motor speed ramp sequencer.
package msrs_pkg;

    localparam int SPEED_W       = 16;
    localparam int TICK_W        = 16;
    localparam int PROD_W        = SPEED_W + TICK_W;
    localparam int DIV_CNT_W     = $clog2(SPEED_W);
    localparam int OP_W          = 2;
    localparam int MODE_W        = 3;
    localparam int IN_DATA_W     = ((SPEED_W + TICK_W + 7) / 8) * 8;
    localparam int OUT_DATA_W    = ((SPEED_W + 7) / 8) * 8;
    localparam int OUT_USER_W    = 2 + MODE_W;

    localparam logic [TICK_W-1:0] STOP_TICKS_RESET = TICK_W'(2000);

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE       = 3'd0,
        MODE_START_RAMP = 3'd1,
        MODE_RAMPING    = 3'd2,
        MODE_AT_SPEED   = 3'd3,
        MODE_START_STOP = 3'd4,
        MODE_STOPPING   = 3'd5
    } mode_t;

    // controller -> datapath
    typedef struct packed {
        logic cap;       // latch the incoming transaction
        logic exec;      // decode and update ramp state
        logic mul;       // delta * elapsed
        logic bias;      // add rounding bias, load divider
        logic div;       // one restoring division step
        logic fin;       // apply quotient to start speed
        logic load_out;  // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;  // tick lands inside the ramp
        logic out_busy;  // output register full and not being taken
    } status_t;

endpackage

### hw/rtl/motor_speed_ramp_sequencer.sv
// Top level of the motor speed ramp sequencer: linear speed ramps driven by start, stop and tick.
//
//   channel   direction  tdata                              tuser
//   s_axis    in         [15:0] target_rpm, [31:16] ramp_ticks  [1:0] operation
//   m_axis    out        [15:0] speed_rpm                   [0] speed_valid, [1] target_reached,
//                                                           [4:2] mode
//   cfg       in         cfg_wr_data = stop_ticks, written when cfg_wr_en is high
//
// Flow: one transaction at a time. Start, stop and ticks that end or skip a ramp
// go from decode straight to the output register. A tick inside a ramp also runs
// one 16x16 multiply, a bias add, and a 16-step
// restoring divider (one quotient bit per cycle) that sets the pace.
// Reset: rst_n clears the ramp state to idle at zero speed; stop_ticks returns to 2000.
// Stalls: the result sits in an output register; a stalled m_axis holds the next
// transaction in its last step, so s_axis_tready stays low until the result register frees up.
module motor_speed_ramp_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,      // stop_ticks
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // [15:0] target_rpm, [31:16] ramp_ticks
    input  logic [1:0]  s_axis_tuser,     // [1:0] operation
    // speed update stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,     // [15:0] speed_rpm
    output logic [4:0]  m_axis_tuser      // [0] speed_valid, [1] target_reached, [4:2] mode
);
    import msrs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: walks each transaction through decode, multiply and divide for ticks inside a ramp, publish
    msrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // ramp state, interpolation arithmetic and the result register
    msrs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .in_user     (s_axis_tuser),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_user    (m_axis_tuser)
    );

endmodule

### hw/rtl/msrs_dp.sv
// Datapath of the speed ramp sequencer: ramp state, multiplier, serial divider, output register.
module msrs_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msrs_pkg::cmd_t                    cmd,
    output msrs_pkg::status_t                 status,
    input  logic                              cfg_wr_en,
    input  logic [msrs_pkg::TICK_W-1:0]       cfg_wr_data,
    input  logic [msrs_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [msrs_pkg::OP_W-1:0]         in_user,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [msrs_pkg::OUT_DATA_W-1:0]   out_data,
    output logic [msrs_pkg::OUT_USER_W-1:0]   out_user
);
    import msrs_pkg::*;

    // captured transaction
    op_t                 op_reg;
    logic [SPEED_W-1:0]  tgt_reg;
    logic [TICK_W-1:0]   rlen_reg;

    // ramp state
    logic [TICK_W-1:0]   stop_ticks_reg;
    mode_t               mode_reg, mode_next;
    logic [SPEED_W-1:0]  cur_reg, cur_next;
    logic [SPEED_W-1:0]  start_reg, start_next;
    logic [SPEED_W-1:0]  goal_reg, goal_next;
    logic [TICK_W-1:0]   len_reg, len_next;
    logic [TICK_W-1:0]   elap_reg, elap_next;
    logic                valid_reg, valid_next;
    logic                reached_reg, reached_next;
    logic                need_div;
    logic                up, dn;

    // arithmetic
    logic [SPEED_W-1:0]  delta_reg;
    logic                down_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   num_sum;
    logic [TICK_W-1:0]   rem_reg;
    logic [SPEED_W-1:0]  quo_reg;
    logic [TICK_W:0]     shifted;
    logic [TICK_W:0]     trial;
    logic                qbit;

    // output stage
    logic                out_valid_reg;
    logic [SPEED_W-1:0]  out_speed_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        goal_next    = goal_reg;
        len_next     = len_reg;
        elap_next    = elap_reg;
        valid_next   = 1'b0;
        reached_next = 1'b0;
        need_div     = 1'b0;
        up           = mode_reg inside {MODE_START_RAMP, MODE_RAMPING};
        dn           = mode_reg inside {MODE_START_STOP, MODE_STOPPING};
        case (op_reg)
            OP_START:
            begin
                start_next = cur_reg;
                goal_next  = tgt_reg;
                len_next   = rlen_reg;
                elap_next  = '0;
                if (rlen_reg != '0)
                begin
                    mode_next = MODE_START_RAMP;
                end
                else
                begin
                    cur_next     = tgt_reg;
                    mode_next    = MODE_AT_SPEED;
                    valid_next   = 1'b1;
                    reached_next = 1'b1;
                end
            end
            OP_STOP:
            begin
                if (up || dn || mode_reg == MODE_AT_SPEED)
                begin
                    start_next = cur_reg;
                    goal_next  = '0;
                    len_next   = stop_ticks_reg;
                    elap_next  = '0;
                    mode_next  = MODE_START_STOP;
                end
                else
                begin
                    cur_next     = '0;
                    mode_next    = MODE_IDLE;
                    valid_next   = 1'b1;
                    reached_next = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (up || dn)
                begin
                    if (elap_reg < len_reg)
                    begin
                        elap_next = elap_reg + TICK_W'(1);
                    end
                    valid_next = 1'b1;
                    if (elap_next >= len_reg)
                    begin
                        reached_next = 1'b1;
                        cur_next     = up ? goal_reg : '0;
                        mode_next    = up ? MODE_AT_SPEED : MODE_IDLE;
                    end
                    else
                    begin
                        need_div  = 1'b1;
                        mode_next = up ? MODE_RAMPING : MODE_STOPPING;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // falling ramp floors toward minus infinity: bias the magnitude up by len-1
    assign num_sum = prod_reg + (down_reg ? PROD_W'(len_reg - TICK_W'(1)) : '0);
    assign shifted = {rem_reg, quo_reg[SPEED_W-1]};
    assign trial   = shifted - {1'b0, len_reg};
    assign qbit    = (shifted >= {1'b0, len_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_ticks_reg <= STOP_TICKS_RESET;
            mode_reg       <= MODE_IDLE;
            cur_reg        <= '0;
            start_reg      <= '0;
            goal_reg       <= '0;
            len_reg        <= '0;
            elap_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                stop_ticks_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                mode_reg  <= mode_next;
                cur_reg   <= cur_next;
                start_reg <= start_next;
                goal_reg  <= goal_next;
                len_reg   <= len_next;
                elap_reg  <= elap_next;
            end
            else if (cmd.fin)
            begin
                cur_reg <= down_reg ? start_reg - quo_reg : start_reg + quo_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg   <= op_t'(in_user);
            tgt_reg  <= in_data[SPEED_W-1:0];
            rlen_reg <= in_data[SPEED_W +: TICK_W];
        end
        if (cmd.exec)
        begin
            valid_reg   <= valid_next;
            reached_reg <= reached_next;
            delta_reg   <= (goal_reg >= start_reg) ? goal_reg - start_reg
                                                   : start_reg - goal_reg;
            down_reg    <= (goal_reg < start_reg);
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(delta_reg) * PROD_W'(elap_reg);
        end
        if (cmd.bias)
        begin
            rem_reg <= num_sum[PROD_W-1:SPEED_W];
            quo_reg <= num_sum[SPEED_W-1:0];
        end
        else if (cmd.div)
        begin
            rem_reg <= qbit ? trial[TICK_W-1:0] : shifted[TICK_W-1:0];
            quo_reg <= {quo_reg[SPEED_W-2:0], qbit};
        end
        if (cmd.load_out)
        begin
            out_speed_reg <= cur_reg;
            out_user_reg  <= {mode_reg, reached_reg, valid_reg};
        end
    end

    assign status.need_div = need_div;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_DATA_W'(out_speed_reg);
    assign out_user  = out_user_reg;

endmodule

### hw/rtl/msrs_ctrl.sv
// Sequencer of the ramp sequencer: one transaction at a time: decode; ramp ticks multiply, divide.
module msrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  msrs_pkg::status_t  status,
    output msrs_pkg::cmd_t     cmd
);
    import msrs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EXEC = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_BIAS = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.need_div ? ST_MUL : ST_EMIT;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_BIAS;
            end
            ST_BIAS:
            begin
                cmd.bias   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(SPEED_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hw/rtl/msrs_checker.sv
// Port-level checks of the motor speed ramp sequencer, bound to the top level.
module msrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser
);
    import msrs_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one transaction in flight: no back-to-back accepts
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a transaction while busy");

    // target reached only in idle or at-speed mode
    a_reached_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[4:2] == MODE_IDLE || m_axis_tuser[4:2] == MODE_AT_SPEED)
        else $error("target reached outside idle or at speed");

    // reaching the target always publishes a speed
    a_reached_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("target reached without speed update");

    // idle means stopped
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[4:2] == MODE_IDLE |-> m_axis_tdata == '0)
        else $error("nonzero speed in idle");

endmodule

bind motor_speed_ramp_sequencer msrs_checker u_msrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
